@@ rtl/fdg_pkg.sv @@
// shared constants and types of the 3d central-difference gradient block
`default_nettype none

package fdg_pkg;

    // volume limits
    localparam int MAX_I = 64;
    localparam int MAX_J = 64;
    localparam int MAX_K = 64;

    // coordinate widths
    localparam int CI_W = $clog2(MAX_I);
    localparam int CJ_W = $clog2(MAX_J);
    localparam int CK_W = $clog2(MAX_K);

    // line and plane store: two of the largest stride, which is one plane
    localparam int STORE_DEPTH = 2 * MAX_I * MAX_J;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int STRIDE_W    = $clog2(MAX_I * MAX_J + 1);
    localparam int SPAN_W      = STRIDE_W + 1;
    localparam int P_W         = $clog2(MAX_I * MAX_J * MAX_K);

    // field widths
    localparam int DATA_W  = 32;
    localparam int POS_W   = 18;
    localparam int SZ_W    = 7;
    localparam int AXIS_W  = 2;
    localparam int INV_W   = 24;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = DATA_W + 1;
    localparam int PROD_W  = DIFF_W + INV_W + 1;

    // configuration port
    localparam int CFG_W     = INV_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_I      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_J      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_K      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = CFG_IDX_W'(4);

    // axis codes
    localparam logic [AXIS_W-1:0] AXIS_I = AXIS_W'(0);
    localparam logic [AXIS_W-1:0] AXIS_J = AXIS_W'(1);
    localparam logic [AXIS_W-1:0] AXIS_K = AXIS_W'(2);

    // result queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
    localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] gradient;
        logic [POS_W-1:0]         position;
        logic                     last;
    } result_t;

    // up to two results enter the queue per cycle
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } outq_push_t;

endpackage

`default_nettype wire

@@ rtl/fdg_sample_if.sv @@
// sample channel: valid, ready and one sample per beat
`default_nettype none

interface fdg_sample_if import fdg_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

@@ rtl/fdg_result_if.sv @@
// result channel: valid, ready and one gradient result per beat
`default_nettype none

interface fdg_result_if import fdg_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] gradient;
    logic [POS_W-1:0]         position;
    logic                     last;

    modport source (output valid, output gradient, output position, output last, input ready);
    modport sink   (input valid, input gradient, input position, input last, output ready);

endinterface

`default_nettype wire

@@ rtl/fdg_ram.sv @@
// generic ram: one write port, two registered read ports, read-first
`default_nettype none

module fdg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // reads return the old word when the same entry is written in that cycle
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fdg_outq.sv @@
// result queue: takes up to two results a cycle, hands out one beat a cycle while ready is high
`default_nettype none

module fdg_outq import fdg_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire outq_push_t   push,
    fdg_result_if.source      results,
    output logic              pop
);

    result_t              q_reg [OUTQ_DEPTH];
    logic [OQ_AW-1:0]     wr_reg;
    logic [OQ_AW-1:0]     wr_next;
    logic [OQ_AW-1:0]     rd_reg;
    logic [OQ_AW-1:0]     rd_next;
    logic [OQ_CW-1:0]     count_reg;
    logic [OQ_CW-1:0]     count_next;
    logic [OQ_AW-1:0]     wr_second;

    // head of queue drives the channel
    assign results.valid    = (count_reg != '0);
    assign results.gradient = q_reg[rd_reg].gradient;
    assign results.position = q_reg[rd_reg].position;
    assign results.last     = q_reg[rd_reg].last;
    assign pop              = results.valid & results.ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_second  = wr_reg + OQ_AW'(1);
        wr_next    = wr_reg + OQ_AW'(push.first_valid) + OQ_AW'(push.second_valid);
        rd_next    = rd_reg + OQ_AW'(pop);
        count_next = count_reg + OQ_CW'(push.first_valid) + OQ_CW'(push.second_valid)
                     - OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // entry storage, the second result always follows a first one
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            q_reg[wr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            q_reg[wr_second] <= push.second;
        end
    end

endmodule

`default_nettype wire

@@ rtl/finite_difference_gradient_3d_core.sv @@
// top level of the streaming 3d central-difference gradient
//
//   channel    dir  handshake          payload
//   samples    in   valid / ready      sample (signed q16.16)
//   results    out  valid / ready      gradient, position, last
//   cfg        in   cfg_we             cfg_index, cfg_data
//
// one sample per cycle while ready is high; results pass s1, s2 and s3 into the queue
// the store of two strides is a ram read at two addresses and written once per accepted sample
// a sample at the end of the chosen axis yields two results; an 8-entry result queue absorbs the
// extra beat and samples stall while the queue and in-flight claims near its depth
// reset clears control only; the store needs no clearing pass
`default_nettype none

module finite_difference_gradient_3d_core import fdg_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    fdg_sample_if.sink                samples,
    fdg_result_if.source              results
);

    typedef struct packed {
        logic             has;
        logic             central;
        logic             two;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
    } item_tag_t;

    localparam logic signed [PROD_W-1:0] RND_ONE_SIDED = PROD_W'(1 << (FRAC_W - 1));
    localparam logic signed [PROD_W-1:0] RND_CENTRAL   = PROD_W'(1 << FRAC_W);
    localparam logic signed [PROD_W-1:0] SAT_HI        = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_LO        = PROD_W'(-64'sd2147483648);

    // rounding to nearest, ties up, then saturation to 32 bits
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] prod,
        input logic                     central
    );
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] q;
        t = prod + (central ? RND_CENTRAL : RND_ONE_SIDED);
        q = central ? (t >>> (FRAC_W + 1)) : (t >>> FRAC_W);
        if (q > SAT_HI)
        begin
            return DATA_W'(SAT_HI);
        end
        else if (q < SAT_LO)
        begin
            return DATA_W'(SAT_LO);
        end
        return DATA_W'(q);
    endfunction

    function automatic logic [SZ_W-1:0] clamp_size(
        input logic [SZ_W-1:0] v,
        input int unsigned     maxv
    );
        if (v < SZ_W'(2))
        begin
            return SZ_W'(2);
        end
        else if (32'(v) > 32'(maxv))
        begin
            return SZ_W'(maxv);
        end
        return v;
    endfunction

    // configuration registers
    logic [AXIS_W-1:0] axis_reg;
    logic [SZ_W-1:0]   size_i_reg;
    logic [SZ_W-1:0]   size_j_reg;
    logic [SZ_W-1:0]   size_k_reg;
    logic [INV_W-1:0]  inv_spacing_reg;
    logic              restart;

    // scan state
    logic [CI_W-1:0]   coord_i_reg;
    logic [CJ_W-1:0]   coord_j_reg;
    logic [CK_W-1:0]   coord_k_reg;
    logic [P_W-1:0]    pos_reg;
    logic [SA_W-1:0]   wp_reg;
    logic [OQ_CW-1:0]  resv_reg;
    logic [OQ_CW-1:0]  resv_next;

    // decode of the current sample
    logic [SZ_W-1:0]     si;
    logic [SZ_W-1:0]     sj;
    logic [SZ_W-1:0]     sk;
    logic [2*SZ_W-1:0]   plane;
    logic [STRIDE_W-1:0] stride;
    logic [SPAN_W-1:0]   span;
    logic [SPAN_W-1:0]   wp_ext;
    logic [SPAN_W-1:0]   s_ext;
    logic [SPAN_W-1:0]   wp_inc;
    logic [SA_W-1:0]     addr_a;
    logic [SZ_W-1:0]     c_sel;
    logic [SZ_W-1:0]     n_sel;
    logic                last_i;
    logic                last_j;
    logic                last_k;
    logic [1:0]          claim;
    logic                accept;
    logic                pop;
    item_tag_t           tag0;
    logic [P_W-1:0]      pos_a_full;

    // pipeline
    logic                      s1_valid_reg;
    logic signed [DATA_W-1:0]  s1_cur_reg;
    item_tag_t                 s1_tag_reg;
    logic signed [DATA_W-1:0]  rd_a;
    logic signed [DATA_W-1:0]  rd_b;
    logic                      s2_valid_reg;
    logic signed [DIFF_W-1:0]  s2_diff0_reg;
    logic signed [DIFF_W-1:0]  s2_diff1_reg;
    item_tag_t                 s2_tag_reg;
    logic                      s3_valid_reg;
    logic signed [PROD_W-1:0]  s3_prod0_reg;
    logic signed [PROD_W-1:0]  s3_prod1_reg;
    item_tag_t                 s3_tag_reg;
    logic signed [INV_W:0]     inv_s;
    outq_push_t                push;

    // register decode; any listed register restarts the volume
    always_comb
    begin
        unique case (cfg_index)
            CFG_AXIS, CFG_SIZE_I, CFG_SIZE_J, CFG_SIZE_K, CFG_INV_SPACING: restart = cfg_we;
            default: restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg        <= AXIS_I;
            size_i_reg      <= SZ_W'(64);
            size_j_reg      <= SZ_W'(64);
            size_k_reg      <= SZ_W'(64);
            inv_spacing_reg <= INV_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AXIS:        axis_reg        <= cfg_data[AXIS_W-1:0];
                CFG_SIZE_I:      size_i_reg      <= cfg_data[SZ_W-1:0];
                CFG_SIZE_J:      size_j_reg      <= cfg_data[SZ_W-1:0];
                CFG_SIZE_K:      size_k_reg      <= cfg_data[SZ_W-1:0];
                CFG_INV_SPACING: inv_spacing_reg <= cfg_data[INV_W-1:0];
                default:         ;
            endcase
        end
    end

    // stride, span and position along the chosen axis
    always_comb
    begin
        si     = clamp_size(size_i_reg, MAX_I);
        sj     = clamp_size(size_j_reg, MAX_J);
        sk     = clamp_size(size_k_reg, MAX_K);
        plane  = (2*SZ_W)'(si) * (2*SZ_W)'(sj);
        last_i = (SZ_W'(coord_i_reg) == si - SZ_W'(1));
        last_j = (SZ_W'(coord_j_reg) == sj - SZ_W'(1));
        last_k = (SZ_W'(coord_k_reg) == sk - SZ_W'(1));
        case (axis_reg)
            AXIS_I:
            begin
                stride = STRIDE_W'(1);
                c_sel  = SZ_W'(coord_i_reg);
                n_sel  = si;
            end
            AXIS_J:
            begin
                stride = STRIDE_W'(si);
                c_sel  = SZ_W'(coord_j_reg);
                n_sel  = sj;
            end
            default:
            begin
                stride = STRIDE_W'(plane);
                c_sel  = SZ_W'(coord_k_reg);
                n_sel  = sk;
            end
        endcase
        span   = {stride, 1'b0};
        wp_ext = SPAN_W'(wp_reg);
        s_ext  = SPAN_W'(stride);
        wp_inc = wp_ext + SPAN_W'(1);
        addr_a = (wp_ext >= s_ext) ? SA_W'(wp_ext - s_ext) : SA_W'(wp_ext + s_ext);

        pos_a_full   = pos_reg - P_W'(stride);
        tag0.has     = (c_sel != '0);
        tag0.central = (c_sel >= SZ_W'(2));
        tag0.two     = (c_sel == n_sel - SZ_W'(1));
        tag0.pos_a   = POS_W'(pos_a_full);
        tag0.pos_b   = POS_W'(pos_reg);
        claim        = tag0.two ? 2'd2 : (tag0.has ? 2'd1 : 2'd0);
    end

    // input takes a beat while queued and in-flight claims leave room for two more results
    assign samples.ready = (resv_reg <= OQ_CW'(OUTQ_DEPTH - 2));
    assign accept        = samples.valid & samples.ready;
    assign resv_next     = resv_reg - OQ_CW'(pop) + (accept ? OQ_CW'(claim) : '0);

    // raster scan counters and store write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_i_reg <= '0;
            coord_j_reg <= '0;
            coord_k_reg <= '0;
            pos_reg     <= '0;
            wp_reg      <= '0;
            resv_reg    <= '0;
        end
        else
        begin
            resv_reg <= resv_next;
            if (restart)
            begin
                coord_i_reg <= '0;
                coord_j_reg <= '0;
                coord_k_reg <= '0;
                pos_reg     <= '0;
                wp_reg      <= '0;
            end
            else if (accept)
            begin
                if (last_i && last_j && last_k)
                begin
                    coord_i_reg <= '0;
                    coord_j_reg <= '0;
                    coord_k_reg <= '0;
                    pos_reg     <= '0;
                    wp_reg      <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + P_W'(1);
                    wp_reg  <= (wp_inc == span) ? '0 : SA_W'(wp_inc);
                    if (last_i)
                    begin
                        coord_i_reg <= '0;
                        if (last_j)
                        begin
                            coord_j_reg <= '0;
                            coord_k_reg <= coord_k_reg + CK_W'(1);
                        end
                        else
                        begin
                            coord_j_reg <= coord_j_reg + CJ_W'(1);
                        end
                    end
                    else
                    begin
                        coord_i_reg <= coord_i_reg + CI_W'(1);
                    end
                end
            end
        end
    end

    // two strides of samples; one stride back and two strides back are read
    fdg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (wp_reg),
        .wdata   (samples.sample),
        .raddr_a (addr_a),
        .raddr_b (wp_reg),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign inv_s = {1'b0, inv_spacing_reg};

    // differences, then products with the reciprocal spacing
    always_ff @(posedge clk)
    begin
        s1_cur_reg   <= samples.sample;
        s1_tag_reg   <= tag0;
        s2_diff0_reg <= DIFF_W'(s1_cur_reg) - DIFF_W'(s1_tag_reg.central ? rd_b : rd_a);
        s2_diff1_reg <= DIFF_W'(s1_cur_reg) - DIFF_W'(rd_a);
        s2_tag_reg   <= s1_tag_reg;
        s3_prod0_reg <= s2_diff0_reg * inv_s;
        s3_prod1_reg <= s2_diff1_reg * inv_s;
        s3_tag_reg   <= s2_tag_reg;
    end

    // rounding and saturation into the result queue
    always_comb
    begin
        push.first_valid       = s3_valid_reg & s3_tag_reg.has;
        push.second_valid      = s3_valid_reg & s3_tag_reg.two;
        push.first.gradient    = round_sat(s3_prod0_reg, s3_tag_reg.central);
        push.first.position    = s3_tag_reg.pos_a;
        push.first.last        = ~s3_tag_reg.two;
        push.second.gradient   = round_sat(s3_prod1_reg, 1'b0);
        push.second.position   = s3_tag_reg.pos_b;
        push.second.last       = 1'b1;
    end

    fdg_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .results (results),
        .pop     (pop)
    );

endmodule

`default_nettype wire
